// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted (active-low reset).
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that must hold on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/vrc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vrc_pkg
// Shared types and constants of the VXLAN receive classifier.
// ============================================================================
package vrc_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNDERLAY_VLAN = 2'd0,
        REG_LOCAL_IP      = 2'd1,
        REG_VXLAN_PORT    = 2'd2,
        REG_VNI_WORD      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_VXLAN = 2'd0,
        CLS_ICMP  = 2'd1,
        CLS_ARP   = 2'd2,
        CLS_DROP  = 2'd3
    } pkt_class_t;

    localparam logic [15:0] ETH_IPV4         = 16'h0800;
    localparam logic [15:0] ETH_ARP          = 16'h0806;
    localparam logic [7:0]  PROTO_UDP        = 8'h11;
    localparam logic [7:0]  PROTO_ICMP       = 8'h01;
    localparam logic [3:0]  IHL_MASK         = 4'hf;
    localparam logic [6:0]  STRIP_BASE       = 7'd30;
    localparam logic [15:0] VXLAN_PORT_RESET = 16'd4789;

    // Byte positions within the frame
    localparam logic [6:0] POS_MAX      = 7'd127;
    localparam logic [6:0] POS_ETH_HI   = 7'd12;
    localparam logic [6:0] POS_ETH_LO   = 7'd13;
    localparam logic [6:0] POS_IHL      = 7'd14;
    localparam logic [6:0] POS_PROTO    = 7'd23;
    localparam logic [6:0] POS_DST_B3   = 7'd30;
    localparam logic [6:0] POS_DST_B2   = 7'd31;
    localparam logic [6:0] POS_DST_B1   = 7'd32;
    localparam logic [6:0] POS_DST_B0   = 7'd33;
    localparam logic [6:0] UDP_BASE     = 7'd14;
    localparam logic [6:0] OFF_PORT_HI  = 7'd2;
    localparam logic [6:0] OFF_PORT_LO  = 7'd3;
    localparam logic [6:0] OFF_VNI_B3   = 7'd12;
    localparam logic [6:0] OFF_VNI_B2   = 7'd13;
    localparam logic [6:0] OFF_VNI_B1   = 7'd14;
    localparam logic [6:0] OFF_VNI_B0   = 7'd15;
    localparam logic [6:0] OFF_VNI_END  = 7'd16;
    localparam logic [7:0] MIN_ETH_LEN  = 8'd14;
    localparam logic [7:0] MIN_IPV4_LEN = 8'd24;
    localparam logic [7:0] MIN_UDP_LEN  = 8'd34;

    typedef struct packed {
        logic [15:0] underlay_vlan;
        logic [31:0] local_ip;
        logic [15:0] vxlan_port;
        logic [31:0] vni_word;
    } vrc_cfg_t;

    // Everything the decision needs, captured on the last byte of a frame
    typedef struct packed {
        logic        vlan_ok;
        logic [6:0]  last_pos;
        logic [15:0] ether_kind;
        logic [7:0]  ip_protocol;
        logic [3:0]  header_words;
        logic        addr_match;
        logic        port_match;
        logic        vni_match;
    } vrc_summary_t;

    function automatic logic [6:0] udp_offset(input logic [3:0] hw);
        return UDP_BASE + {1'b0, hw, 2'b00};
    endfunction

endpackage

// ----- sv/vxlan_rx_classifier_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vxlan_rx_classifier_top
// Byte-serial VXLAN/ICMP/ARP receive classifier with a register write port.
// ============================================================================
// The classifier takes one frame byte per clock, with no bubbles, as long as
// the summary queue has room; each frame gives one result beat after its last
// byte, via the queue into the output register. Throughput is set by the byte
// parser, which handles one byte per cycle while the queue has room; the queue
// of QUEUE_DEPTH frame summaries lets the output side stall for that many
// frames before input backpressure starts, and the output register lets a new
// result load in the same cycle one is taken. The class is VXLAN, ICMP, ARP or
// drop; strip length is nonzero only for VXLAN. Registers are written through
// the cfg port by the user, only while the block is idle; the block does not
// enforce it. cfg_ready is always high. No clearing pass is needed after reset.
module vxlan_rx_classifier_top
    import vrc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Byte input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // [7:0] data_byte, [23:8] tag_value
    input  logic                  s_axis_tlast,  // pkt_last
    input  logic [1:0]            s_axis_tuser,  // [0] pkt_first, [1] tag_stripped
    // Result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [6:0] strip_bytes, [7] zero
    output logic [1:0]            m_axis_tuser   // [1:0] pkt_class
);

    vrc_cfg_t     cfg_reg, cfg_next;
    vrc_summary_t push_data, pop_data;
    logic         push, pop, q_full, q_not_empty;
    pkt_class_t   out_class;
    logic [6:0]   out_strip;

    assign cfg_ready = 1'b1;

    // Register file: hold the value unless a write beat lands on it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_UNDERLAY_VLAN: cfg_next.underlay_vlan = cfg_data[15:0];
                REG_LOCAL_IP:      cfg_next.local_ip      = cfg_data;
                REG_VXLAN_PORT:    cfg_next.vxlan_port    = cfg_data[15:0];
                REG_VNI_WORD:      cfg_next.vni_word      = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.underlay_vlan <= '0;
            cfg_reg.local_ip      <= '0;
            cfg_reg.vxlan_port    <= VXLAN_PORT_RESET;
            cfg_reg.vni_word      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: parse each byte, push a summary on the last beat of a frame
    vrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .byte_valid   (s_axis_tvalid),
        .byte_ready   (s_axis_tready),
        .data_byte    (s_axis_tdata[7:0]),
        .pkt_first    (s_axis_tuser[0]),
        .pkt_last     (s_axis_tlast),
        .tag_stripped (s_axis_tuser[1]),
        .tag_value    (s_axis_tdata[23:8]),
        .queue_full   (q_full),
        .push         (push),
        .summary      (push_data)
    );

    vrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    // Back: decide the class and drive the result beat
    vrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_class (out_class),
        .out_strip (out_strip)
    );

    assign m_axis_tdata = {1'b0, out_strip};
    assign m_axis_tuser = out_class;

endmodule

// ----- sv/vrc_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vrc_queue
// Small FIFO of frame summaries between the parser and the decision stage.
// ============================================================================
`include "assert_macros.svh"
module vrc_queue
    import vrc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  vrc_summary_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output vrc_summary_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    vrc_summary_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, (count_reg <= CNT_W'(DEPTH)), "queue count overflow")
    `ASSERT_RST(a_push_grows, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue push lost")

endmodule

// ----- sv/vrc_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vrc_front
// Byte parser: tracks position, captures header fields, compares addresses.
// ============================================================================
`include "assert_macros.svh"
module vrc_front
    import vrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  vrc_cfg_t     cfg,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  logic [7:0]   data_byte,
    input  logic         pkt_first,
    input  logic         pkt_last,
    input  logic         tag_stripped,
    input  logic [15:0]  tag_value,
    input  logic         queue_full,
    output logic         push,
    output vrc_summary_t summary
);

    logic [6:0]  pos_reg, pos_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic        vlan_ok_reg, vlan_ok_next;
    logic        addr_match_reg, addr_match_next;
    logic        port_match_reg, port_match_next;
    logic        vni_match_reg, vni_match_next;

    logic        accept;
    logic [6:0]  pos;
    logic [15:0] ek_cur;
    logic [3:0]  hw_cur;
    logic [7:0]  proto_cur;
    logic        vlan_cur;
    logic        addr_cur, port_cur, vni_cur;
    logic [6:0]  udp;
    logic [6:0]  off;
    logic        in_udp;
    logic [7:0]  want;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign push       = accept && pkt_last;

    always_comb
    begin
        // Start of frame: drop what came before
        pos       = pkt_first ? '0 : pos_reg;
        ek_cur    = pkt_first ? '0 : ether_kind_reg;
        hw_cur    = pkt_first ? '0 : header_words_reg;
        proto_cur = pkt_first ? '0 : ip_protocol_reg;
        vlan_cur  = pkt_first ? ((cfg.underlay_vlan == '0) ||
                                 (tag_stripped && (tag_value == cfg.underlay_vlan)))
                              : vlan_ok_reg;
        addr_cur  = pkt_first ? 1'b1 : addr_match_reg;
        port_cur  = pkt_first ? 1'b1 : port_match_reg;
        vni_cur   = pkt_first ? 1'b1 : vni_match_reg;

        if (pos == POS_ETH_HI || pos == POS_ETH_LO)
        begin
            ek_cur = {ek_cur[7:0], data_byte};
        end
        if (pos == POS_IHL)
        begin
            hw_cur = data_byte[3:0] & IHL_MASK;
        end
        if (pos == POS_PROTO)
        begin
            proto_cur = data_byte;
        end

        case (pos)
            POS_DST_B3: if (data_byte != cfg.local_ip[31:24]) addr_cur = 1'b0;
            POS_DST_B2: if (data_byte != cfg.local_ip[23:16]) addr_cur = 1'b0;
            POS_DST_B1: if (data_byte != cfg.local_ip[15:8])  addr_cur = 1'b0;
            POS_DST_B0: if (data_byte != cfg.local_ip[7:0])   addr_cur = 1'b0;
            default: ;
        endcase

        udp    = udp_offset(hw_cur);
        in_udp = (pos >= udp);
        off    = pos - udp;

        if (in_udp && off == OFF_PORT_HI && data_byte != cfg.vxlan_port[15:8])
        begin
            port_cur = 1'b0;
        end
        if (in_udp && off == OFF_PORT_LO && data_byte != cfg.vxlan_port[7:0])
        begin
            port_cur = 1'b0;
        end

        case (off)
            OFF_VNI_B3: want = cfg.vni_word[31:24];
            OFF_VNI_B2: want = cfg.vni_word[23:16];
            OFF_VNI_B1: want = cfg.vni_word[15:8];
            OFF_VNI_B0: want = cfg.vni_word[7:0];
            default:    want = data_byte;
        endcase
        if (in_udp && data_byte != want)
        begin
            vni_cur = 1'b0;
        end

        summary.vlan_ok      = vlan_cur;
        summary.last_pos     = pos;
        summary.ether_kind   = ek_cur;
        summary.ip_protocol  = proto_cur;
        summary.header_words = hw_cur;
        summary.addr_match   = addr_cur;
        summary.port_match   = port_cur;
        summary.vni_match    = vni_cur;

        pos_next          = pos_reg;
        ether_kind_next   = ether_kind_reg;
        header_words_next = header_words_reg;
        ip_protocol_next  = ip_protocol_reg;
        vlan_ok_next      = vlan_ok_reg;
        addr_match_next   = addr_match_reg;
        port_match_next   = port_match_reg;
        vni_match_next    = vni_match_reg;
        if (accept)
        begin
            if (pkt_last)
            begin
                pos_next          = '0;
                ether_kind_next   = '0;
                header_words_next = '0;
                ip_protocol_next  = '0;
                vlan_ok_next      = 1'b0;
                addr_match_next   = 1'b1;
                port_match_next   = 1'b1;
                vni_match_next    = 1'b1;
            end
            else
            begin
                pos_next          = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
                ether_kind_next   = ek_cur;
                header_words_next = hw_cur;
                ip_protocol_next  = proto_cur;
                vlan_ok_next      = vlan_cur;
                addr_match_next   = addr_cur;
                port_match_next   = port_cur;
                vni_match_next    = vni_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            ether_kind_reg   <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            vlan_ok_reg      <= 1'b0;
            addr_match_reg   <= 1'b1;
            port_match_reg   <= 1'b1;
            vni_match_reg    <= 1'b1;
        end
        else
        begin
            pos_reg          <= pos_next;
            ether_kind_reg   <= ether_kind_next;
            header_words_reg <= header_words_next;
            ip_protocol_reg  <= ip_protocol_next;
            vlan_ok_reg      <= vlan_ok_next;
            addr_match_reg   <= addr_match_next;
            port_match_reg   <= port_match_next;
            vni_match_reg    <= vni_match_next;
        end
    end

    `ASSERT_RST(a_last_clears, clk, rst_n, push |=> (pos_reg == '0 && !vlan_ok_reg), "frame state not cleared after last beat")

endmodule

// ----- sv/vrc_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vrc_back
// Decision stage: turns a frame summary into class and strip length.
// ============================================================================
`include "assert_macros.svh"
module vrc_back
    import vrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  vrc_summary_t q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output pkt_class_t   out_class,
    output logic [6:0]   out_strip
);

    logic       out_valid_reg, out_valid_next;
    pkt_class_t class_reg;
    logic [6:0] strip_reg;

    pkt_class_t cls;
    logic [6:0] strip;
    logic [7:0] len;
    logic [7:0] need;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_class = class_reg;
    assign out_strip = strip_reg;

    always_comb
    begin
        len  = {1'b0, q_data.last_pos} + 8'd1;
        need = {1'b0, udp_offset(q_data.header_words) + OFF_VNI_END};
        if (need < MIN_UDP_LEN)
        begin
            need = MIN_UDP_LEN;
        end
        cls   = CLS_DROP;
        strip = '0;
        if (q_data.vlan_ok && len >= MIN_ETH_LEN)
        begin
            if (q_data.ether_kind == ETH_IPV4)
            begin
                if (len >= MIN_IPV4_LEN)
                begin
                    if (q_data.ip_protocol == PROTO_UDP)
                    begin
                        if (len >= need && q_data.addr_match && q_data.port_match &&
                            q_data.vni_match)
                        begin
                            cls   = CLS_VXLAN;
                            strip = STRIP_BASE + {1'b0, q_data.header_words, 2'b00};
                        end
                    end
                    else if (q_data.ip_protocol == PROTO_ICMP)
                    begin
                        cls = CLS_ICMP;
                    end
                end
            end
            else if (q_data.ether_kind == ETH_ARP)
            begin
                cls = CLS_ARP;
            end
        end

        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            class_reg <= cls;
            strip_reg <= strip;
        end
    end

    `ASSERT_RST(a_strip_only_vxlan, clk, rst_n, (out_valid_reg && class_reg != CLS_VXLAN) |-> (strip_reg == '0), "strip length on non-VXLAN result")
    `ASSERT_RST(a_strip_floor, clk, rst_n, (out_valid_reg && class_reg == CLS_VXLAN) |-> (strip_reg >= STRIP_BASE), "VXLAN strip below base")

endmodule
